// ===== rtl/core/wac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wac_pkg
// Shared types and constants for the wrench average and calibrate block.
// ----------------------------------------------------------------------------
package wac_pkg;

  localparam int AXES        = 6;
  localparam int CNT_W       = 7;
  localparam int MAX_AVG     = 64;
  localparam int COUNT_RESET = 10;
  localparam int COEF_W      = 18;
  localparam int AXIS_W      = 3;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAC,
    ST_SAT,
    ST_OUT
  } back_state_t;

  // calibration matrix, signed Q2.16
  function automatic logic signed [COEF_W-1:0] cal_coef(input logic [AXIS_W-1:0] row,
                                                       input logic [AXIS_W-1:0] col);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case ({row, col})
      6'o00: c = 18'sd67084;  6'o01: c = 18'sd1758;   6'o02: c = -18'sd159;
      6'o03: c = 18'sd3733;   6'o04: c = -18'sd12874; 6'o05: c = 18'sd10001;
      6'o10: c = -18'sd1125;  6'o11: c = 18'sd66187;  6'o12: c = -18'sd782;
      6'o13: c = 18'sd10398;  6'o14: c = -18'sd358;   6'o15: c = 18'sd809;
      6'o20: c = 18'sd463;    6'o21: c = 18'sd621;    6'o22: c = 18'sd65204;
      6'o23: c = 18'sd380;    6'o24: c = 18'sd2972;   6'o25: c = 18'sd489;
      6'o30: c = 18'sd50;     6'o31: c = 18'sd85;     6'o32: c = -18'sd47;
      6'o33: c = 18'sd66884;  6'o34: c = -18'sd144;   6'o35: c = 18'sd4;
      6'o40: c = -18'sd99;    6'o41: c = 18'sd5;      6'o42: c = -18'sd13;
      6'o43: c = 18'sd262;    6'o44: c = 18'sd67182;  6'o45: c = -18'sd375;
      6'o50: c = 18'sd73;     6'o51: c = -18'sd135;   6'o52: c = -18'sd4;
      6'o53: c = -18'sd131;   6'o54: c = 18'sd916;    6'o55: c = 18'sd66758;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/wac_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wac_if
// Valid/ready channel carrying six signed axis values.
// ----------------------------------------------------------------------------
interface wac_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] force_x;
  logic signed [W-1:0] force_y;
  logic signed [W-1:0] force_z;
  logic signed [W-1:0] torque_x;
  logic signed [W-1:0] torque_y;
  logic signed [W-1:0] torque_z;

  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  input ready);
  modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  output ready);
endinterface

// ===== rtl/core/wac_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wac_res_if
// Valid/ready channel carrying averaged and calibrated axis values.
// ----------------------------------------------------------------------------
interface wac_res_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] avg_force_x;
  logic signed [W-1:0] avg_force_y;
  logic signed [W-1:0] avg_force_z;
  logic signed [W-1:0] avg_torque_x;
  logic signed [W-1:0] avg_torque_y;
  logic signed [W-1:0] avg_torque_z;
  logic signed [W-1:0] cal_force_x;
  logic signed [W-1:0] cal_force_y;
  logic signed [W-1:0] cal_force_z;
  logic signed [W-1:0] cal_torque_x;
  logic signed [W-1:0] cal_torque_y;
  logic signed [W-1:0] cal_torque_z;

  modport source (output valid, avg_force_x, avg_force_y, avg_force_z, avg_torque_x,
                  avg_torque_y, avg_torque_z, cal_force_x, cal_force_y, cal_force_z,
                  cal_torque_x, cal_torque_y, cal_torque_z, input ready);
  modport sink   (input valid, avg_force_x, avg_force_y, avg_force_z, avg_torque_x,
                  avg_torque_y, avg_torque_z, cal_force_x, cal_force_y, cal_force_z,
                  cal_torque_x, cal_torque_y, cal_torque_z, output ready);
endinterface

// ===== rtl/core/wac_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wac_front
// Accumulates samples per axis and hands a finished window (its six sums)
// to the back end through a one-entry queue.
// ----------------------------------------------------------------------------
module wac_front
  import wac_pkg::*;
#(
  parameter int W   = 32,
  parameter int S_W = 38
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [AXES-1:0][W-1:0] in_samp,
  input  logic [CNT_W-1:0]           count_eff,
  output logic                       win_valid,
  input  logic                       win_ready,
  output logic signed [AXES-1:0][S_W-1:0] win_sums
);

  logic signed [AXES-1:0][S_W-1:0] sums_r, sums_nxt;
  logic [CNT_W-1:0]                seen_r, seen_nxt;
  logic                            q_valid_r;
  logic signed [AXES-1:0][S_W-1:0] q_sums_r;
  logic                            accept, fire;
  logic [CNT_W-1:0]                seen_inc;

  // stall while a finished window waits in the queue
  assign in_ready = !q_valid_r;
  assign accept   = in_valid && in_ready;
  assign seen_inc = seen_r + 1'b1;
  assign fire     = accept && (seen_inc >= count_eff);

  // running sums
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sums_nxt[i] = sums_r[i] + S_W'($signed(in_samp[i]));
    end
    seen_nxt = seen_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r    <= '0;
      seen_r    <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (fire) begin
          sums_r <= '0;
          seen_r <= '0;
        end else begin
          sums_r <= sums_nxt;
          seen_r <= seen_nxt;
        end
      end
      if (fire) q_valid_r <= 1'b1;
      else if (win_ready) q_valid_r <= 1'b0;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (fire) q_sums_r <= sums_nxt;
  end

  assign win_valid = q_valid_r;
  assign win_sums  = q_sums_r;

endmodule

// ===== rtl/core/wac_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wac_back
// Divides the six sums by the count with a shared restoring divider, runs a
// shared multiply-accumulate over the 6x6 matrix, saturates and holds the
// result until taken.
// ----------------------------------------------------------------------------
module wac_back
  import wac_pkg::*;
#(
  parameter int W   = 32,
  parameter int S_W = 38
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          win_valid,
  output logic                          win_ready,
  input  logic signed [AXES-1:0][S_W-1:0] win_sums,
  input  logic [CNT_W-1:0]              count_eff,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic signed [AXES-1:0][W-1:0] res_avg,
  output logic signed [AXES-1:0][W-1:0] res_cal
);

  localparam int ACC_W = W + COEF_W + 4;
  localparam int DB_W  = $clog2(S_W + 1);
  localparam int PH_W  = S_W - 16;

  back_state_t state_r, state_nxt;

  logic signed [AXES-1:0][S_W-1:0] sums_r;
  logic signed [AXES-1:0][S_W-1:0] avg_r;
  logic signed [AXES-1:0][W-1:0]   cal_r;
  logic [AXIS_W-1:0]               ax_r;
  logic [AXIS_W-1:0]               col_r;
  logic [DB_W-1:0]                 bit_r;
  logic [S_W-1:0]                  mag_r;
  logic [CNT_W:0]                  rem_r;
  logic [S_W-1:0]                  quo_r;
  logic signed [ACC_W-1:0]         acc_hi_r;
  logic signed [ACC_W-1:0]         acc_lo_r;
  logic                            neg_r;
  logic                            out_valid_r;

  // restoring division step
  logic [CNT_W:0] rem_sh;
  logic [CNT_W:0] rem_sub;
  logic           div_ge;
  assign rem_sh  = {rem_r[CNT_W-1:0], mag_r[S_W-1]};
  assign div_ge  = rem_sh >= {1'b0, count_eff};
  assign rem_sub = div_ge ? rem_sh - {1'b0, count_eff} : rem_sh;

  // multiply-accumulate operands: average split as hi*2^16 + lo
  logic signed [COEF_W-1:0]      coef;
  logic signed [PH_W-1:0]        a_hi;
  logic signed [16:0]            a_lo;
  logic signed [S_W-1:0]         a_cur;
  logic signed [COEF_W+PH_W-1:0] p_hi;
  logic signed [COEF_W+16:0]     p_lo;
  assign a_cur = avg_r[col_r];
  assign coef  = cal_coef(ax_r, col_r);
  assign a_hi  = PH_W'(a_cur >>> 16);
  assign a_lo  = {1'b0, a_cur[15:0]};
  assign p_hi  = coef * a_hi;
  assign p_lo  = coef * a_lo;

  // rounding and saturation
  logic signed [ACC_W-1:0] cal_full;
  logic signed [ACC_W-1:0] hi_lim;
  logic signed [ACC_W-1:0] lo_lim;
  logic signed [W-1:0]     cal_sat;
  assign cal_full = acc_hi_r + ((acc_lo_r + ACC_W'(32768)) >>> 16);
  assign hi_lim   = ACC_W'({1'b0, {(W-1){1'b1}}});
  assign lo_lim   = -hi_lim - ACC_W'(1);
  always_comb begin
    if (cal_full > hi_lim)      cal_sat = {1'b0, {(W-1){1'b1}}};
    else if (cal_full < lo_lim) cal_sat = {1'b1, {(W-1){1'b0}}};
    else                        cal_sat = W'(cal_full);
  end

  logic last_ax;
  logic last_col;
  assign last_ax  = ax_r == AXIS_W'(AXES - 1);
  assign last_col = col_r == AXIS_W'(AXES - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (win_valid) state_nxt = ST_DIV;
      ST_DIV:  if (bit_r == DB_W'(S_W - 1) && last_ax) state_nxt = ST_MAC;
      ST_MAC:  if (last_col) state_nxt = ST_SAT;
      ST_SAT:  if (last_ax) state_nxt = ST_OUT;
               else state_nxt = ST_MAC;
      ST_OUT:  if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    win_ready   = 1'b0;
    out_valid_r = 1'b0;
    case (state_r)
      ST_IDLE: win_ready   = 1'b1;
      ST_OUT:  out_valid_r = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sums_r <= win_sums;
        ax_r   <= '0;
        bit_r  <= '0;
        rem_r  <= '0;
        neg_r  <= win_sums[0][S_W-1];
        mag_r  <= win_sums[0][S_W-1] ? -win_sums[0] : win_sums[0];
      end
      ST_DIV: begin
        if (bit_r == DB_W'(S_W - 1)) begin
          quo_r <= {quo_r[S_W-2:0], div_ge};
          avg_r[ax_r] <= neg_r ? -{quo_r[S_W-2:0], div_ge}
                               : {quo_r[S_W-2:0], div_ge};
          bit_r <= '0;
          rem_r <= '0;
          if (last_ax) begin
            ax_r     <= '0;
            col_r    <= '0;
            acc_hi_r <= '0;
            acc_lo_r <= '0;
          end else begin
            ax_r  <= ax_r + 1'b1;
            neg_r <= sums_r[ax_r + 1'b1][S_W-1];
            mag_r <= sums_r[ax_r + 1'b1][S_W-1] ? -sums_r[ax_r + 1'b1]
                                                 : sums_r[ax_r + 1'b1];
          end
        end else begin
          rem_r <= rem_sub;
          quo_r <= {quo_r[S_W-2:0], div_ge};
          mag_r <= {mag_r[S_W-2:0], 1'b0};
          bit_r <= bit_r + 1'b1;
        end
      end
      ST_MAC: begin
        acc_hi_r <= acc_hi_r + ACC_W'(p_hi);
        acc_lo_r <= acc_lo_r + ACC_W'(p_lo);
        col_r    <= last_col ? '0 : col_r + 1'b1;
      end
      ST_SAT: begin
        cal_r[ax_r] <= cal_sat;
        acc_hi_r    <= '0;
        acc_lo_r    <= '0;
        ax_r        <= last_ax ? '0 : ax_r + 1'b1;
      end
      default: ;
    endcase
  end

  // averages are emitted at the output width
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      res_avg[i] = avg_r[i][W-1:0];
    end
  end

  assign res_valid = out_valid_r;
  assign res_cal   = cal_r;

endmodule

// ===== rtl/core/wrench_average_calibrate_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrench_average_calibrate_top
// Boxcar average of six-axis samples followed by a fixed 6x6 calibration.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one six-axis sample per item, valid/ready.
//  - out_ch carries one result (six averages, six calibrated values) per
//    window of average_count samples; other items produce nothing.
//  - cfg_we/cfg_wdata set average_count (0 acts as 1, above 64 acts as 64).
//  - the front end takes one item per cycle until a window closes; the window
//    then sits in a one-entry queue for the back end.
//  - back end per window: a shared bit-serial divider forms the six averages,
//    then a multiply-accumulate and saturate step per axis gives the calibrated
//    values; the result is then held until taken.
//  - a stalled receiver holds the back end; the front end keeps summing the
//    next window and stalls only when that window also closes.
//  - reset clears sums, count and all valid flags; average_count goes to 10.
// ----------------------------------------------------------------------------
module wrench_average_calibrate_top
  import wac_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  wac_if.sink               in_ch,
  wac_res_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  localparam int S_W = SAMPLE_WIDTH + 6;

  logic [CNT_W-1:0] avg_cnt_r;
  logic [CNT_W-1:0] count_eff;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)      avg_cnt_r <= CNT_W'(COUNT_RESET);
    else if (cfg_we) avg_cnt_r <= cfg_wdata;
  end

  // clamp to 1..64
  always_comb begin
    if (avg_cnt_r == '0)                   count_eff = CNT_W'(1);
    else if (avg_cnt_r > CNT_W'(MAX_AVG))  count_eff = CNT_W'(MAX_AVG);
    else                                   count_eff = avg_cnt_r;
  end

  logic signed [AXES-1:0][SAMPLE_WIDTH-1:0] in_samp;
  assign in_samp[0] = in_ch.force_x;
  assign in_samp[1] = in_ch.force_y;
  assign in_samp[2] = in_ch.force_z;
  assign in_samp[3] = in_ch.torque_x;
  assign in_samp[4] = in_ch.torque_y;
  assign in_samp[5] = in_ch.torque_z;

  logic                               win_valid, win_ready;
  logic signed [AXES-1:0][S_W-1:0]    win_sums;
  logic signed [AXES-1:0][SAMPLE_WIDTH-1:0] res_avg, res_cal;

  wac_front #(.W(SAMPLE_WIDTH), .S_W(S_W)) u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_samp,
    .count_eff,
    .win_valid,
    .win_ready,
    .win_sums
  );

  wac_back #(.W(SAMPLE_WIDTH), .S_W(S_W)) u_back (
    .clk, .rst_n,
    .win_valid,
    .win_ready,
    .win_sums,
    .count_eff,
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_avg,
    .res_cal
  );

  assign out_ch.avg_force_x  = res_avg[0];
  assign out_ch.avg_force_y  = res_avg[1];
  assign out_ch.avg_force_z  = res_avg[2];
  assign out_ch.avg_torque_x = res_avg[3];
  assign out_ch.avg_torque_y = res_avg[4];
  assign out_ch.avg_torque_z = res_avg[5];
  assign out_ch.cal_force_x  = res_cal[0];
  assign out_ch.cal_force_y  = res_cal[1];
  assign out_ch.cal_force_z  = res_cal[2];
  assign out_ch.cal_torque_x = res_cal[3];
  assign out_ch.cal_torque_y = res_cal[4];
  assign out_ch.cal_torque_z = res_cal[5];

  // checks
  a_eff_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_eff != '0 && count_eff <= CNT_W'(MAX_AVG))
    else $error("effective count out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_cal))
    else $error("result changed while stalled");

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready |=> !out_ch.valid)
    else $error("result repeated");

endmodule

// ===== tb/sv/wrench_average_calibrate_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrench_average_calibrate_top_tb
// Drives six-axis samples through the averaging and calibration block and
// checks every averaged and calibrated result against a local predictor.
// Several averaging counts are used, 0 and 127 among them, with random idling
// on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module wrench_average_calibrate_top_tb;
  import wac_pkg::*;

  localparam int W = 32;
  localparam int HALF = 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef logic signed [W-1:0] axis_vec_t [AXES];

  typedef struct {
    axis_vec_t avg;
    axis_vec_t cal;
  } wrench_result_t;

  // window averager and calibration predictor
  class wrench_scoreboard;
    logic signed [W+5:0] sums [AXES];
    int unsigned         seen;
    logic [CNT_W-1:0]    avg_count;
    wrench_result_t      pending [$];
    int unsigned         errors;

    function void clear_state();
      foreach (sums[i]) sums[i] = '0;
      seen = 0;
      avg_count = CNT_W'(COUNT_RESET);
      pending.delete();
      errors = 0;
    endfunction

    function automatic int cal_rom(int r, int c);
      int rom [AXES][AXES] = '{
        '{67084, 1758, -159, 3733, -12874, 10001},
        '{-1125, 66187, -782, 10398, -358, 809},
        '{463, 621, 65204, 380, 2972, 489},
        '{50, 85, -47, 66884, -144, 4},
        '{-99, 5, -13, 262, 67182, -375},
        '{73, -135, -4, -131, 916, 66758}};
      return rom[r][c];
    endfunction

    function automatic logic signed [W-1:0] clamp(longint x);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (W - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return W'(hi);
      if (x < lo) return W'(lo);
      return W'(x);
    endfunction

    // note one accepted sample
    function void note_sample(axis_vec_t s);
      int eff;
      longint a [AXES];
      longint acc;
      wrench_result_t r;
      foreach (s[i]) sums[i] += s[i];
      seen = (seen + 1) & 8'h7f;
      eff = int'(avg_count);
      if (eff < 1) eff = 1;
      if (eff > MAX_AVG) eff = MAX_AVG;
      if (seen < eff) return;
      for (int i = 0; i < AXES; i++) begin
        a[i] = longint'(sums[i]) / eff;
        r.avg[i] = a[i][W-1:0];
      end
      // products fit in 64 bits, so floor of the rounded sum is exact
      for (int i = 0; i < AXES; i++) begin
        acc = 0;
        for (int j = 0; j < AXES; j++)
          acc += longint'(cal_rom(i, j)) * a[j];
        r.cal[i] = clamp((acc + 32768) >>> 16);
      end
      pending.push_back(r);
      foreach (sums[i]) sums[i] = '0;
      seen = 0;
    endfunction

    task report(string what, int idx, logic [W-1:0] got, logic [W-1:0] want);
      $display("mismatch %s[%0d]: got %h want %h", what, idx, got, want);
      errors++;
    endtask

    // check one accepted result against the oldest expectation
    task check_result(wrench_result_t got);
      wrench_result_t want;
      if (pending.size() == 0) begin
        report("unexpected", 0, got.avg[0], '0);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < AXES; i++) begin
        if (got.avg[i] !== want.avg[i]) report("avg", i, got.avg[i], want.avg[i]);
        if (got.cal[i] !== want.cal[i]) report("cal", i, got.cal[i], want.cal[i]);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  wac_if #(.W(W)) in_ch ();
  wac_res_if #(.W(W)) out_ch ();

  wrench_average_calibrate_top #(.SAMPLE_WIDTH(W)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #HALF clk = ~clk;

  wrench_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.force_x = '0; in_ch.force_y = '0; in_ch.force_z = '0;
    in_ch.torque_x = '0; in_ch.torque_y = '0; in_ch.torque_z = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    wrench_result_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.avg = '{out_ch.avg_force_x, out_ch.avg_force_y, out_ch.avg_force_z,
                out_ch.avg_torque_x, out_ch.avg_torque_y, out_ch.avg_torque_z};
      r.cal = '{out_ch.cal_force_x, out_ch.cal_force_y, out_ch.cal_force_z,
                out_ch.cal_torque_x, out_ch.cal_torque_y, out_ch.cal_torque_z};
      sb.check_result(r);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one sample and wait until it is taken
  task automatic send_sample(axis_vec_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.force_x <= s[0]; in_ch.force_y <= s[1]; in_ch.force_z <= s[2];
    in_ch.torque_x <= s[3]; in_ch.torque_y <= s[4]; in_ch.torque_z <= s[5];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s);
  endtask

  function automatic logic signed [W-1:0] rand_axis();
    case ($urandom_range(9))
      0: return {1'b0, {(W-1){1'b1}}};
      1: return {1'b1, {(W-1){1'b0}}};
      2, 3: return $signed(W'($urandom_range(4000000))) - 2000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(int n);
    axis_vec_t s;
    repeat (n) begin
      foreach (s[i]) s[i] = rand_axis();
      send_sample(s);
    end
  endtask

  // stop offering, wait for all results, then let the back end settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.avg_count = v;
  endtask

  initial begin
    axis_vec_t s;
    logic [CNT_W-1:0] counts [8] = '{0, 1, 2, 3, 7, 64, 127, 5};
    sb.clear_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes at reset count, then single-sample windows
    s = '{default: {1'b0, {(W-1){1'b1}}}};
    repeat (10) send_sample(s);
    s = '{default: {1'b1, {(W-1){1'b0}}}};
    repeat (10) send_sample(s);
    drain();
    write_count(0);
    s = '{default: {1'b0, {(W-1){1'b1}}}}; send_sample(s);
    s = '{default: {1'b1, {(W-1){1'b0}}}}; send_sample(s);
    s = '{-1, 1, -3, 3, -65536, 65535}; send_sample(s);
    s = '{default: '0}; send_sample(s);
    drain();
    // lowering the count mid-window emits on the next sample
    write_count(9);
    send_random(4);
    drain();
    write_count(2);
    send_random(1);
    drain();

    // random phases over several counts and idling profiles
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 25; recv_idle_pct = 63;
      end else if (ph < 6) begin
        send_idle_pct = 63; recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_count(counts[ph]);
      if (ph == 6) send_random(128);
      else if (ph == 7) begin
        // receiver holds off while the sender keeps the block full
        hold_cycles = 3000;
        send_random(150);
      end else send_random(counts[ph] > 10 ? 192 : 80);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
